FILE: hdl/fvof_pkg.sv
package fvof_pkg;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_VOTE  = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   localparam logic [1:0] CSR_DIFF_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_MIN_POSITIVE   = 2'd1;
   localparam logic [1:0] CSR_POSITIVE_RATIO = 2'd2;
   localparam logic [1:0] CSR_BIN_SHIFT      = 2'd3;

   localparam int unsigned COUNT_W = 10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] first_x;
      logic [15:0] first_y;
      logic [15:0] second_x;
      logic [15:0] second_y;
      logic [9:0]  query_index;
   } req_type;

   typedef struct packed {
      logic        is_summary;
      logic [9:0]  match_index;
      logic        keep;
      logic [9:0]  positive_votes;
      logic [9:0]  total_votes;
      logic [10:0] kept_total;
   } rsp_type;

   // One stored match: flow and grid bin.
   typedef struct packed {
      logic               valid;
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic [7:0]         bx;
      logic [7:0]         by;
   } match_type;

   typedef struct packed {
      logic        clear;
      logic        load;
      logic        vote_start;
      logic        rotate;
      logic        count_en;
      logic        decide;
      logic        disabled;
      logic [15:0] diff_threshold;
      logic [9:0]  min_votes;
      logic [8:0]  ratio;
   } ctrl_type;

endpackage

FILE: hdl/flow_voting_outlier_filter.sv
// Matches are held in a ring of MAX_MATCHES cells, one match per cell. Clear,
// load and query leave the block idle, so a new command may follow at once; a
// query answer appears on the cycle after it is taken. A vote always runs its
// full course whatever the number of loaded matches: a rotate phase in which
// every stored match travels round the ring and meets every other cell, a
// decide step for the keep decision in each cell, and a sum phase for the kept
// count to ripple down the chain. busy is high for that whole time. Results are
// shown for one cycle under rsp_valid and cannot be held off by the receiver.
module flow_voting_outlier_filter
   import fvof_pkg::*;
#(
   parameter int MAX_MATCHES = 1024,
   parameter int GRID_X      = 16,
   parameter int GRID_Y      = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CW = $clog2(MAX_MATCHES + 1);
   localparam int IW = $clog2(MAX_MATCHES);
   localparam int QW = (CW > 10) ? CW : 10;

   typedef enum logic [1:0] {ST_IDLE, ST_ROTATE, ST_DECIDE, ST_SUM} state_type;

   state_type   state_ff;
   logic [CW-1:0] step_ff;
   logic [CW-1:0] count_ff;
   logic [10:0] kept_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [15:0] thr_ff;
   logic [9:0]  min_ff;
   logic [8:0]  ratio_ff;
   logic [4:0]  shift_ff;

   ctrl_type  ctrl;
   match_type new_match;
   logic      accept;
   logic [15:0] sh_x;
   logic [15:0] sh_y;

   match_type          travel [MAX_MATCHES];
   logic [10:0]        acc    [MAX_MATCHES];
   logic               ckeep  [MAX_MATCHES];
   logic [COUNT_W-1:0] cpos   [MAX_MATCHES];
   logic [COUNT_W-1:0] ctot   [MAX_MATCHES];

   logic [IW-1:0] q_sel;
   logic          q_in_range;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      sh_x = req_data.second_x >> shift_ff;
      sh_y = req_data.second_y >> shift_ff;
      new_match.valid = 1'b1;
      new_match.dx = 17'({1'b0, req_data.second_x}) - 17'({1'b0, req_data.first_x});
      new_match.dy = 17'({1'b0, req_data.second_y}) - 17'({1'b0, req_data.first_y});
      new_match.bx = (32'(sh_x) < GRID_X) ? 8'(sh_x) : 8'(GRID_X - 1);
      new_match.by = (32'(sh_y) < GRID_Y) ? 8'(sh_y) : 8'(GRID_Y - 1);

      ctrl.clear      = accept && req_data.cmd == CMD_CLEAR;
      ctrl.load       = accept && req_data.cmd == CMD_LOAD && 32'(count_ff) < MAX_MATCHES;
      ctrl.vote_start = accept && req_data.cmd == CMD_VOTE;
      ctrl.rotate     = (state_ff == ST_ROTATE);
      ctrl.decide     = (state_ff == ST_DECIDE);
      ctrl.disabled   = (thr_ff == '0) || (min_ff == '0) || (ratio_ff == '0);
      ctrl.count_en   = !ctrl.disabled;
      ctrl.diff_threshold = thr_ff;
      ctrl.min_votes  = min_ff;
      ctrl.ratio      = ratio_ff;

      q_sel      = IW'(req_data.query_index);
      q_in_range = QW'(req_data.query_index) < QW'(count_ff);
   end

   for (genvar i = 0; i < MAX_MATCHES; i++) begin : g_cell
      fvof_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sel        (count_ff == CW'(i)),
         .load_match (new_match),
         .travel_in  (travel[(i + MAX_MATCHES - 1) % MAX_MATCHES]),
         .travel_out (travel[i]),
         .acc_in     ((i == 0) ? 11'd0 : acc[(i + MAX_MATCHES - 1) % MAX_MATCHES]),
         .acc_out    (acc[i]),
         .keep       (ckeep[i]),
         .pos_count  (cpos[i]),
         .tot_count  (ctot[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= 16'd32;
         min_ff       <= 10'd4;
         ratio_ff     <= 9'd128;
         shift_ff     <= 5'd10;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DIFF_THRESHOLD: thr_ff   <= csr_data;
               CSR_MIN_POSITIVE:   min_ff   <= csr_data[9:0];
               CSR_POSITIVE_RATIO: ratio_ff <= csr_data[8:0];
               CSR_BIN_SHIFT:      shift_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_data.cmd)
                     CMD_CLEAR: begin
                        count_ff <= '0;
                        kept_ff  <= '0;
                     end
                     CMD_LOAD: begin
                        if (ctrl.load) count_ff <= count_ff + 1'b1;
                     end
                     CMD_VOTE: begin
                        step_ff  <= '0;
                        state_ff <= (MAX_MATCHES > 1) ? ST_ROTATE : ST_DECIDE;
                     end
                     CMD_QUERY: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff.is_summary  <= 1'b0;
                        rsp_ff.match_index <= req_data.query_index;
                        rsp_ff.keep        <= q_in_range && ckeep[q_sel];
                        rsp_ff.positive_votes <= q_in_range ? cpos[q_sel] : '0;
                        rsp_ff.total_votes    <= q_in_range ? ctot[q_sel] : '0;
                        rsp_ff.kept_total  <= kept_ff;
                     end
                     default: ;
                  endcase
               end
            end
            ST_ROTATE: begin
               step_ff <= step_ff + 1'b1;
               if (32'(step_ff) == MAX_MATCHES - 2) state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               step_ff  <= '0;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               // The kept count ripples through one acc register per cell to reach the end,
               // once the fresh keep bits have entered the chain.
               step_ff <= step_ff + 1'b1;
               if (32'(step_ff) == MAX_MATCHES) begin
                  state_ff     <= ST_IDLE;
                  kept_ff      <= acc[MAX_MATCHES - 1];
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.is_summary     <= 1'b1;
                  rsp_ff.match_index    <= '0;
                  rsp_ff.keep           <= 1'b0;
                  rsp_ff.positive_votes <= '0;
                  rsp_ff.total_votes    <= '0;
                  rsp_ff.kept_total     <= acc[MAX_MATCHES - 1];
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/fvof_cell.sv
module fvof_cell
   import fvof_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   input  logic                sel,
   input  match_type           load_match,
   input  match_type           travel_in,
   output match_type           travel_out,
   input  logic [10:0]         acc_in,
   output logic [10:0]         acc_out,
   output logic                keep,
   output logic [COUNT_W-1:0]  pos_count,
   output logic [COUNT_W-1:0]  tot_count
);

   match_type          home_ff;
   match_type          travel_ff;
   logic               valid_ff;
   logic               keep_ff;
   logic [COUNT_W-1:0] pos_ff;
   logic [COUNT_W-1:0] tot_ff;
   logic [10:0]        acc_ff;

   match_type          home_vote;
   logic signed [17:0] ddx;
   logic signed [17:0] ddy;
   logic [17:0]        adx;
   logic [17:0]        ady;
   logic [18:0]        flow_gap;
   logic               adjacent;
   logic               pair_ok;
   logic [18:0]        need_full;
   logic [COUNT_W:0]   need;

   always_comb begin
      home_vote = home_ff;
      home_vote.valid = valid_ff;
      ddx = 18'(travel_in.dx) - 18'(home_ff.dx);
      ddy = 18'(travel_in.dy) - 18'(home_ff.dy);
      adx = ddx[17] ? 18'(-ddx) : 18'(ddx);
      ady = ddy[17] ? 18'(-ddy) : 18'(ddy);
      flow_gap = 19'(adx) + 19'(ady);
      adjacent = ((travel_in.bx >= home_ff.bx) ? (travel_in.bx - home_ff.bx) <= 8'd1
                                               : (home_ff.bx - travel_in.bx) <= 8'd1) &&
                 ((travel_in.by >= home_ff.by) ? (travel_in.by - home_ff.by) <= 8'd1
                                               : (home_ff.by - travel_in.by) <= 8'd1);
      pair_ok = ctrl.count_en && valid_ff && travel_in.valid && adjacent;
      need_full = 19'(tot_ff) * 19'(ctrl.ratio);
      need = need_full[8 +: COUNT_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         keep_ff  <= 1'b0;
         pos_ff   <= '0;
         tot_ff   <= '0;
         acc_ff   <= '0;
      end else begin
         acc_ff <= acc_in + 11'(keep_ff);
         if (ctrl.clear) begin
            valid_ff <= 1'b0;
         end else if (ctrl.load && sel) begin
            home_ff  <= load_match;
            valid_ff <= 1'b1;
            keep_ff  <= 1'b0;
            pos_ff   <= '0;
            tot_ff   <= '0;
         end else if (ctrl.vote_start) begin
            travel_ff <= home_vote;
            pos_ff <= '0;
            tot_ff <= '0;
         end else if (ctrl.rotate) begin
            travel_ff <= travel_in;
            if (pair_ok) begin
               if (tot_ff != COUNT_MAX) tot_ff <= tot_ff + 1'b1;
               if (flow_gap < 19'(ctrl.diff_threshold) && pos_ff != COUNT_MAX)
                  pos_ff <= pos_ff + 1'b1;
            end
         end else if (ctrl.decide) begin
            keep_ff <= valid_ff && (ctrl.disabled || pos_ff >= ctrl.min_votes ||
                                    {1'b0, pos_ff} >= need);
         end
      end
   end

   assign travel_out = travel_ff;
   assign acc_out    = acc_ff;
   assign keep       = keep_ff;
   assign pos_count  = pos_ff;
   assign tot_count  = tot_ff;

endmodule

FILE: hdl/fvof_checker.sv
module fvof_checker
   import fvof_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic taken;
   assign taken = start && !busy;

   a_query_answers: assert property (@(posedge clock) disable iff (reset)
      taken && req_data.cmd == CMD_QUERY |=> rsp_valid && !rsp_data.is_summary)
      else $error("query word not answered on the next cycle");

   a_vote_busy: assert property (@(posedge clock) disable iff (reset)
      taken && req_data.cmd == CMD_VOTE |=> busy && !rsp_valid)
      else $error("vote word did not raise busy");

   a_quiet_cmds: assert property (@(posedge clock) disable iff (reset)
      taken && (req_data.cmd == CMD_CLEAR || req_data.cmd == CMD_LOAD) |=> !rsp_valid)
      else $error("clear or load word produced a result");

   a_summary_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_summary |-> rsp_data.match_index == '0 &&
         !rsp_data.keep && rsp_data.positive_votes == '0 && rsp_data.total_votes == '0)
      else $error("summary word carries per-match fields");

   a_summary_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_summary |-> !busy && $past(busy))
      else $error("summary word outside the end of a vote");

endmodule

bind flow_voting_outlier_filter fvof_checker u_fvof_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
